### hw/rtl/ttyle_pkg.sv
// shared types, codes and constants of the tty line discipline echo unit
package ttyle_pkg;

   localparam int BUF_DEPTH_DEF = 64;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // request types on req_tuser
   localparam logic [1:0] REQ_RECV = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_SEND = 2'd2;

   // result kinds on rsp_tuser
   localparam logic [1:0] KIND_TX       = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_NOTREADY = 2'd2;

   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_BS     = 8'h08;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_FS     = 8'h1C;
   localparam logic [7:0] CHR_SP     = 8'h20;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_CARET  = 8'h5E;
   localparam logic [7:0] CHR_DEL    = 8'h7F;
   localparam logic [7:0] CTRL_OFS   = 8'h40;

   typedef enum logic [2:0] {
      OP_STORE      = 3'd0,
      OP_ECHO_STORE = 3'd1,
      OP_SEND       = 3'd2,
      OP_ERASE      = 3'd3,
      OP_READ       = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] chr;
      logic [7:0] e0;
      logic [7:0] e1;
      logic       two;
   } cmd_type;

endpackage

### hw/rtl/ttyle_front.sv
// front end: accepts requests, maps echo characters, holds the echo enable register
module ttyle_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // data_byte
   input  logic [1:0]         req_tuser,   // req_type
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data,    // echo_enable
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output ttyle_pkg::cmd_type cmd
);
   import ttyle_pkg::*;

   logic    echo_ff, echo_in;
   logic    fr_valid_ff, fr_valid_in;
   cmd_type fr_cmd_ff, fr_cmd_in;
   logic    accept;
   logic    known;
   logic [7:0] chr;

   assign csr_ready  = 1'b1;
   assign req_tready = !fr_valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = fr_valid_ff;
   assign cmd        = fr_cmd_ff;

   always_comb begin
      echo_in = echo_ff;
      if (csr_valid && csr_ready) begin
         echo_in = csr_data;
      end
   end

   always_comb begin
      chr = req_tdata;
      if (req_tuser == REQ_RECV && req_tdata == CHR_CR) begin
         chr = CHR_LF;
      end
      known         = 1'b1;
      fr_cmd_in     = fr_cmd_ff;
      fr_cmd_in.chr = chr;
      fr_cmd_in.e0  = chr;
      fr_cmd_in.e1  = chr;
      fr_cmd_in.two = 1'b0;
      fr_cmd_in.op  = OP_SEND;
      unique case (req_tuser)
         REQ_RECV: begin
            if (!echo_ff) begin
               fr_cmd_in.op = OP_STORE;
            end else if (chr == CHR_BS || chr == CHR_DEL) begin
               fr_cmd_in.op = OP_ERASE;
            end else begin
               fr_cmd_in.op = OP_ECHO_STORE;
               priority if (chr == CHR_LF) begin
                  fr_cmd_in.e0  = CHR_CR;
                  fr_cmd_in.e1  = CHR_LF;
                  fr_cmd_in.two = 1'b1;
               end else if (chr == CHR_NUL) begin
                  fr_cmd_in.e0  = CHR_CARET;
                  fr_cmd_in.e1  = CHR_ZERO;
                  fr_cmd_in.two = 1'b1;
               end else if (chr == CHR_FS) begin
                  fr_cmd_in.e0  = CHR_CARET;
                  fr_cmd_in.e1  = CHR_BSLASH;
                  fr_cmd_in.two = 1'b1;
               end else if (chr < CHR_SP) begin
                  fr_cmd_in.e0  = CHR_CARET;
                  fr_cmd_in.e1  = chr + CTRL_OFS;
                  fr_cmd_in.two = 1'b1;
               end else begin
                  fr_cmd_in.two = 1'b0;
               end
            end
         end
         REQ_READ: begin
            fr_cmd_in.op = OP_READ;
         end
         REQ_SEND: begin
            fr_cmd_in.op = OP_SEND;
            if (chr == CHR_LF) begin
               fr_cmd_in.e0  = CHR_CR;
               fr_cmd_in.e1  = CHR_LF;
               fr_cmd_in.two = 1'b1;
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         fr_valid_in = known;
      end else begin
         fr_valid_in = fr_valid_ff && !cmd_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff     <= 1'b1;
         fr_valid_ff <= 1'b0;
      end else begin
         echo_ff     <= echo_in;
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_cmd_ff <= fr_cmd_in;
      end
   end

endmodule

### hw/rtl/ttyle_cmd_fifo.sv
// short command queue between front end and back end
module ttyle_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ttyle_pkg::cmd_type push_cmd,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ttyle_pkg::cmd_type pop_cmd
);
   import ttyle_pkg::*;

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign push_ready = cnt_ff != Q_CNT_W'(Q_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/ttyle_back.sv
// back end: line buffer, pointers and counts, result sequencing and output register
module ttyle_back #(
   parameter int BUF_DEPTH = ttyle_pkg::BUF_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  ttyle_pkg::cmd_type cmd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // out_byte
   output logic [1:0]         rsp_tuser,   // out_kind
   output logic               rsp_tlast
);
   import ttyle_pkg::*;

   localparam int PTR_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);

   localparam logic [1:0] SQ_PAIR   = 2'd0;
   localparam logic [1:0] SQ_ERASE3 = 2'd1;
   localparam logic [1:0] SQ_ERASE6 = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   logic [7:0]       mem [BUF_DEPTH];
   logic [7:0]       rdata_ff;
   logic             wr_en, rd_en;
   logic [PTR_W-1:0] rd_addr;

   state_type        st_ff, st_in;
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, wp_next, wp_prev, rp_next;
   logic [CNT_W-1:0] fill_ff, fill_in, nl_ff, nl_in;
   logic             lk_read_ff, lk_read_in;

   logic [1:0]       sq_kind_ff, sq_kind_in;
   logic [1:0]       sq_mode_ff, sq_mode_in;
   logic [7:0]       sq_b0_ff, sq_b0_in, sq_b1_ff, sq_b1_in;
   logic [2:0]       sq_cnt_ff, sq_cnt_in, sq_idx_ff, sq_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free, seq_last;
   logic [7:0]       seq_byte;

   assign cmd_ready  = st_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign wp_next = (wp_ff == PTR_W'(BUF_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign wp_prev = (wp_ff == '0) ? PTR_W'(BUF_DEPTH - 1) : wp_ff - 1'b1;
   assign rp_next = (rp_ff == PTR_W'(BUF_DEPTH - 1)) ? '0 : rp_ff + 1'b1;

   assign seq_last = sq_idx_ff == sq_cnt_ff - 3'd1;

   always_comb begin
      unique case (sq_mode_ff)
         SQ_ERASE3: seq_byte = (sq_idx_ff == 3'd1) ? CHR_SP : CHR_BS;
         SQ_ERASE6: seq_byte = (sq_idx_ff == 3'd2 || sq_idx_ff == 3'd3) ? CHR_SP : CHR_BS;
         default:   seq_byte = (sq_idx_ff == 3'd0) ? sq_b0_ff : sq_b1_ff;
      endcase
   end

   always_comb begin
      st_in        = st_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      nl_in        = nl_ff;
      lk_read_in   = lk_read_ff;
      sq_kind_in   = sq_kind_ff;
      sq_mode_in   = sq_mode_ff;
      sq_b0_in     = sq_b0_ff;
      sq_b1_in     = sq_b1_ff;
      sq_cnt_in    = sq_cnt_ff;
      sq_idx_in    = sq_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = rp_ff;

      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if ((cmd.op == OP_STORE || cmd.op == OP_ECHO_STORE)
                   && fill_ff != CNT_W'(BUF_DEPTH)) begin
                  wr_en   = 1'b1;
                  wp_in   = wp_next;
                  fill_in = fill_ff + 1'b1;
                  if (cmd.chr == CHR_LF) begin
                     nl_in = nl_ff + 1'b1;
                  end
               end
               unique case (cmd.op)
                  OP_ECHO_STORE, OP_SEND: begin
                     sq_kind_in = KIND_TX;
                     sq_mode_in = SQ_PAIR;
                     sq_b0_in   = cmd.e0;
                     sq_b1_in   = cmd.e1;
                     sq_cnt_in  = cmd.two ? 3'd2 : 3'd1;
                     sq_idx_in  = '0;
                     st_in      = ST_EMIT;
                  end
                  OP_ERASE: begin
                     if (fill_ff != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = wp_prev;
                        lk_read_in = 1'b0;
                        st_in      = ST_LOOK;
                     end
                  end
                  OP_READ: begin
                     if (nl_ff != '0 && fill_ff != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = rp_ff;
                        lk_read_in = 1'b1;
                        st_in      = ST_LOOK;
                     end else begin
                        sq_kind_in = KIND_NOTREADY;
                        sq_mode_in = SQ_PAIR;
                        sq_b0_in   = CHR_NUL;
                        sq_cnt_in  = 3'd1;
                        sq_idx_in  = '0;
                        st_in      = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOK: begin
            if (lk_read_ff) begin
               rp_in   = rp_next;
               fill_in = fill_ff - 1'b1;
               if (rdata_ff == CHR_LF) begin
                  nl_in = nl_ff - 1'b1;
               end
               sq_kind_in = KIND_DATA;
               sq_mode_in = SQ_PAIR;
               sq_b0_in   = rdata_ff;
               sq_cnt_in  = 3'd1;
               sq_idx_in  = '0;
               st_in      = ST_EMIT;
            end else if (rdata_ff == CHR_LF) begin
               // completed line stays put
               st_in = ST_IDLE;
            end else begin
               wp_in      = wp_prev;
               fill_in    = fill_ff - 1'b1;
               sq_kind_in = KIND_TX;
               sq_mode_in = (rdata_ff < CHR_SP) ? SQ_ERASE6 : SQ_ERASE3;
               sq_cnt_in  = (rdata_ff < CHR_SP) ? 3'd6 : 3'd3;
               sq_idx_in  = '0;
               st_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = seq_byte;
               rsp_kind_in  = sq_kind_ff;
               rsp_last_in  = seq_last;
               sq_idx_in    = sq_idx_ff + 3'd1;
               if (seq_last) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         nl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         nl_ff        <= nl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lk_read_ff  <= lk_read_in;
      sq_kind_ff  <= sq_kind_in;
      sq_mode_ff  <= sq_mode_in;
      sq_b0_ff    <= sq_b0_in;
      sq_b1_ff    <= sq_b1_in;
      sq_cnt_ff   <= sq_cnt_in;
      sq_idx_ff   <= sq_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= cmd.chr;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(BUF_DEPTH))
      else $error("fill count above buffer depth");

   a_nl_le_fill: assert property (@(posedge clock) disable iff (reset)
      nl_ff <= fill_ff)
      else $error("more line ends than buffered bytes");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> fill_ff != CNT_W'(BUF_DEPTH))
      else $error("buffer write while full");

   a_look_once: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_LOOK |=> st_ff != ST_LOOK)
      else $error("buffer lookup held for more than one cycle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_EMIT |-> (sq_idx_ff < sq_cnt_ff))
      else $error("result index past sequence length");

endmodule

### hw/rtl/tty_line_discipline_echo_unit.sv
// top level: tty line discipline with echo, line editing and line-gated reads
// an echoed or transmitted byte passes the front end register, the command queue, the
//   back end sequencer and the output register; a read or backspace also passes a
//   lookup state for the line buffer read port; the sequencer gives one result per
//   cycle while the output is not stalled and takes a new item only when idle
// reset clears pointers, counts and queues and sets echo on; buffer contents are not cleared
module tty_line_discipline_echo_unit #(
   parameter int BUF_DEPTH = ttyle_pkg::BUF_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic [1:0] req_tuser,   // req_type
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [1:0] rsp_tuser,   // out_kind
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // echo_enable
);
   import ttyle_pkg::*;

   logic    fr_valid, fr_ready;
   cmd_type fr_cmd;
   logic    bk_valid, bk_ready;
   cmd_type bk_cmd;

   ttyle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd_valid  (fr_valid),
      .cmd_ready  (fr_ready),
      .cmd        (fr_cmd)
   );

   ttyle_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_cmd   (fr_cmd),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_cmd    (bk_cmd)
   );

   ttyle_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (bk_valid),
      .cmd_ready  (bk_ready),
      .cmd        (bk_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
